// ===== src/lsv_pkg.sv =====
// Shared definitions for the 3x3 linear solver.
// Default word and fraction widths and the status flag bundle; no dependencies.
package lsv_pkg;

	localparam int WORD_BITS_DEF     = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// status that rides beside each solution
	typedef struct packed {
		logic saturated;
		logic singular;
	} lsv_flags_t;

endpackage

// ===== src/lsv_adjugate.sv =====
// Adjugate front end: input register, 2x2 minor products, cofactors.
// Three pipeline stages under a common clock enable; uses lsv_pkg.
module lsv_adjugate #(
	parameter int WORD_BITS = lsv_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        vld_in,
	input  logic signed [WORD_BITS-1:0] a_in [9],
	input  logic signed [WORD_BITS-1:0] b_in [3],
	output logic                        vld_out,
	output logic signed [2*WORD_BITS:0] adj [9],
	output logic signed [WORD_BITS-1:0] row0 [3],
	output logic signed [WORD_BITS-1:0] b_out [3]
);
	import lsv_pkg::*;

	localparam int W = WORD_BITS;
	localparam int C = 2 * W + 1;
	// operand pairs of the 18 products, by flat matrix index; cofactor k = p[2k] - p[2k+1]
	localparam int PA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
	localparam int PB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

	logic                    vld_s1, vld_s2, vld_s3;
	logic signed [W-1:0]     a_s1 [9];
	logic signed [W-1:0]     b_s1 [3];
	logic signed [2*W-1:0]   p_s2 [18];
	logic signed [W-1:0]     r0_s2 [3];
	logic signed [W-1:0]     b_s2 [3];
	logic signed [C-1:0]     adj_s3 [9];
	logic signed [W-1:0]     r0_s3 [3];
	logic signed [W-1:0]     b_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			a_s1 <= a_in;
			b_s1 <= b_in;
			for (int i = 0; i < 18; i++) begin
				p_s2[i] <= a_s1[PA[i]] * a_s1[PB[i]];
			end
			for (int i = 0; i < 3; i++) begin
				r0_s2[i] <= a_s1[i];
				b_s2[i]  <= b_s1[i];
			end
			for (int k = 0; k < 9; k++) begin
				adj_s3[k] <= C'(p_s2[2*k]) - C'(p_s2[2*k+1]);
			end
			r0_s3 <= r0_s2;
			b_s3  <= b_s2;
		end
	end

	assign vld_out = vld_s3;
	assign adj     = adj_s3;
	assign row0    = r0_s3;
	assign b_out   = b_s3;

endmodule

// ===== src/lsv_accum.sv =====
// Determinant and adjugate-times-vector accumulation.
// Split wide products into two narrow halves, merge, then sum; uses lsv_pkg.
module lsv_accum #(
	parameter int WORD_BITS = lsv_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            ce,
	input  logic                            vld_in,
	input  logic signed [2*WORD_BITS:0]     adj [9],
	input  logic signed [WORD_BITS-1:0]     row0 [3],
	input  logic signed [WORD_BITS-1:0]     b_in [3],
	output logic                            vld_out,
	output logic signed [3*WORD_BITS+2:0]   det,
	output logic signed [3*WORD_BITS+2:0]   num [3]
);
	import lsv_pkg::*;

	localparam int W = WORD_BITS;
	localparam int C = 2 * W + 1;
	localparam int D = 3 * W + 3;

	typedef logic signed [D-1:0] dword_t;

	logic                  vld_s4, vld_s5, vld_s6;
	logic signed [W-1:0]   x_op [12];
	logic signed [C-1:0]   c_op [12];
	logic signed [2*W:0]   lo_s4 [12];
	logic signed [2*W:0]   hi_s4 [12];
	dword_t                term_s5 [12];
	dword_t                det_s6;
	dword_t                num_s6 [3];

	// terms 0..2 build det along row 0, terms 3+3r+c build row r of adj*b
	always_comb begin
		for (int t = 0; t < 3; t++) begin
			x_op[t] = row0[t];
			c_op[t] = adj[3*t];
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				x_op[3 + 3*r + c] = b_in[c];
				c_op[3 + 3*r + c] = adj[3*r + c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (ce) begin
			vld_s4 <= vld_in;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int t = 0; t < 12; t++) begin
				lo_s4[t]   <= x_op[t] * $signed({1'b0, c_op[t][W-1:0]});
				hi_s4[t]   <= x_op[t] * $signed(c_op[t][C-1:W]);
				term_s5[t] <= (dword_t'(hi_s4[t]) <<< W) + dword_t'(lo_s4[t]);
			end
			det_s6 <= term_s5[0] + term_s5[1] + term_s5[2];
			for (int r = 0; r < 3; r++) begin
				num_s6[r] <= term_s5[3+3*r] + term_s5[4+3*r] + term_s5[5+3*r];
			end
		end
	end

	assign vld_out = vld_s6;
	assign det     = det_s6;
	assign num     = num_s6;

endmodule

// ===== src/lsv_divider.sv =====
// Pipelined restoring divider: x = trunc(num * 2^F / det), saturated to W bits.
// One quotient bit per stage after an overflow check; uses lsv_pkg.
module lsv_divider #(
	parameter int WORD_BITS     = lsv_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = lsv_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          ce,
	input  logic                          vld_in,
	input  logic signed [3*WORD_BITS+2:0] num,
	input  logic signed [3*WORD_BITS+2:0] det,
	output logic                          vld_out,
	output logic signed [WORD_BITS-1:0]   x,
	output lsv_pkg::lsv_flags_t           flags
);
	import lsv_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int D  = 3 * W + 3;
	localparam int NM = D + F;

	logic            vld_p;
	logic [D-1:0]    mn_p, md_p;
	logic            neg_p, zero_p;
	logic [NM-1:0]   mn_sh;

	logic            vld_s [W+1];
	logic [D-1:0]    rem_s [W+1];
	logic [D-1:0]    md_s  [W+1];
	logic [W-1:0]    low_s [W+1];
	logic [W-1:0]    q_s   [W+1];
	logic            neg_s [W+1];
	logic            zero_s[W+1];
	logic            ovf_s [W+1];

	logic            vld_o;
	logic [W-1:0]    x_o;
	lsv_flags_t      flags_o;

	// prep: magnitudes and sign of the quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
		end else if (ce) begin
			vld_p <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mn_p   <= num[D-1] ? D'(-num) : D'(num);
			md_p   <= det[D-1] ? D'(-det) : D'(det);
			neg_p  <= num[D-1] ^ det[D-1];
			zero_p <= (det == '0);
		end
	end

	assign mn_sh = {mn_p, {F{1'b0}}};

	// quotient at or above 2^W saturates; otherwise the top part is already below md
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= vld_p;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0]  <= D'(mn_sh[NM-1:W]);
			low_s[0]  <= mn_sh[W-1:0];
			md_s[0]   <= md_p;
			q_s[0]    <= '0;
			neg_s[0]  <= neg_p;
			zero_s[0] <= zero_p;
			ovf_s[0]  <= ((D+W)'(mn_sh) >= {md_p, {W{1'b0}}});
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic [D:0] trial;
		logic       ge;

		assign trial = {rem_s[k], low_s[k][W-1]};
		assign ge    = (trial >= {1'b0, md_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ce) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rem_s[k+1]  <= ge ? D'(trial - {1'b0, md_s[k]}) : D'(trial);
				low_s[k+1]  <= {low_s[k][W-2:0], 1'b0};
				q_s[k+1]    <= {q_s[k][W-2:0], ge};
				md_s[k+1]   <= md_s[k];
				neg_s[k+1]  <= neg_s[k];
				zero_s[k+1] <= zero_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	// clip, apply sign, force zero when singular
	logic [W-1:0] lim;
	logic         sat;
	logic [W-1:0] mag;

	always_comb begin
		lim = neg_s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		sat = ovf_s[W] || (q_s[W] > lim);
		mag = sat ? lim : q_s[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (ce) begin
			vld_o <= vld_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (zero_s[W]) begin
				x_o               <= '0;
				flags_o.singular  <= 1'b1;
				flags_o.saturated <= 1'b0;
			end else begin
				x_o               <= neg_s[W] ? (~mag + 1'b1) : mag;
				flags_o.singular  <= 1'b0;
				flags_o.saturated <= sat;
			end
		end
	end

	assign vld_out = vld_o;
	assign x       = $signed(x_o);
	assign flags   = flags_o;

endmodule

// ===== src/linear_solve_3x3.sv =====
// Solves A*x = b for one signed Q(W-F).F 3x3 system per beat, by adjugate over determinant.
// x_i = trunc(adj(A)b_i * 2^F / det) saturated to W bits; singular gives zeros.
// Takes one beat every cycle while s_tready is high; the divider resolves one quotient bit
// per pipeline stage. A two-entry output buffer parks one more result while a result waits
// to be taken, and holds off input while its spare entry is full.
module linear_solve_3x3 #(
	parameter int WORD_BITS     = lsv_pkg::WORD_BITS_DEF,
	parameter int FRACTION_BITS = lsv_pkg::FRACTION_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, v0, v1, v2
	input  logic [((12*WORD_BITS+7)/8)*8-1:0]        s_tdata,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// x0, x1, x2
	output logic [((3*WORD_BITS+7)/8)*8-1:0]         m_tdata,
	// singular, saturated
	output logic [1:0]                              m_tuser
);
	import lsv_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int D   = 3 * W + 3;
	localparam int MDB = ((3*W+7)/8)*8;

	logic                 ce;
	logic signed [W-1:0]  a_in [9];
	logic signed [W-1:0]  b_in [3];

	logic                 adj_vld;
	logic signed [2*W:0]  adj [9];
	logic signed [W-1:0]  row0 [3];
	logic signed [W-1:0]  b_mid [3];

	logic                 acc_vld;
	logic signed [D-1:0]  det;
	logic signed [D-1:0]  num [3];

	logic                 div_vld;
	logic [2:0]           div_vld_all;
	logic signed [W-1:0]  x_res [3];
	lsv_flags_t           fl_res [3];

	logic                 out_vld_q, skid_vld_q;
	logic [3*W-1:0]       out_x_q, skid_x_q;
	lsv_flags_t           out_fl_q, skid_fl_q;
	logic                 take;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			a_in[i] = $signed(s_tdata[i*W +: W]);
		end
		for (int i = 0; i < 3; i++) begin
			b_in[i] = $signed(s_tdata[(9+i)*W +: W]);
		end
	end

	// the whole pipe holds only while a result sits in the spare buffer entry
	assign ce       = !skid_vld_q;
	assign s_tready = ce;

	lsv_adjugate #(.WORD_BITS(W)) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.vld_in  (s_tvalid),
		.a_in    (a_in),
		.b_in    (b_in),
		.vld_out (adj_vld),
		.adj     (adj),
		.row0    (row0),
		.b_out   (b_mid)
	);

	lsv_accum #(.WORD_BITS(W)) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ce      (ce),
		.vld_in  (adj_vld),
		.adj     (adj),
		.row0    (row0),
		.b_in    (b_mid),
		.vld_out (acc_vld),
		.det     (det),
		.num     (num)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		if (i == 0) begin : g_lead
			lsv_divider #(.WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_div (
				.clk     (clk),
				.arst_n  (arst_n),
				.ce      (ce),
				.vld_in  (acc_vld),
				.num     (num[i]),
				.det     (det),
				.vld_out (div_vld_all[i]),
				.x       (x_res[i]),
				.flags   (fl_res[i])
			);
		end else begin : g_side
			lsv_divider #(.WORD_BITS(W), .FRACTION_BITS(FRACTION_BITS)) u_div (
				.clk     (clk),
				.arst_n  (arst_n),
				.ce      (ce),
				.vld_in  (acc_vld),
				.num     (num[i]),
				.det     (det),
				.vld_out (div_vld_all[i]),
				.x       (x_res[i]),
				.flags   (fl_res[i])
			);
		end
	end

	assign div_vld = div_vld_all[0];

	lsv_flags_t fl_all;
	always_comb begin
		fl_all.singular  = fl_res[0].singular;
		fl_all.saturated = fl_res[0].saturated | fl_res[1].saturated | fl_res[2].saturated;
	end

	assign take = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (div_vld) begin
			if (out_vld_q && !take) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_x_q  <= skid_x_q;
				out_fl_q <= skid_fl_q;
			end
		end else if (div_vld) begin
			if (out_vld_q && !take) begin
				skid_x_q  <= {x_res[2], x_res[1], x_res[0]};
				skid_fl_q <= fl_all;
			end else begin
				out_x_q  <= {x_res[2], x_res[1], x_res[0]};
				out_fl_q <= fl_all;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = MDB'(out_x_q);
	assign m_tuser  = {out_fl_q.saturated, out_fl_q.singular};

	// spare entry is used only behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("spare entry holds a beat while output is empty");

	// a singular system never reports clipping and returns zeros
	a_singular_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (!m_tuser[1] && out_x_q == '0))
		else $error("singular result is not clean");

	// a result arriving while the buffer is full would be lost
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> !($past(div_vld) && $past(ce)))
		else $error("result arrived while output buffer was full");

	// after a beat is parked in the spare entry, input is held off
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld && ce && out_vld_q && !m_tready) |=> !s_tready)
		else $error("input accepted with output buffer full");

	// the three divider lanes advance in lockstep
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_all == {3{div_vld_all[0]}})
		else $error("divider lanes out of step");

endmodule
